// ===== design/pfrs_pkg.sv =====
// Shared types and constants for the pulse flow rate smoother.
`default_nettype none
package pfrs_pkg;

  localparam int unsigned DVD_W = 36;
  localparam int unsigned DVS_W = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int unsigned RATE_W = 16;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned PROD_W = 26;
  localparam int unsigned RATE_MUL = 60 * 10;
  localparam int unsigned VOL_MUL = 10;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_LITRE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_FLOW_THRESHOLD = 2'd2;

  localparam logic [15:0] PPL_RESET = 16'd450;
  localparam logic [3:0] AVG_LEN_RESET = 4'd4;
  localparam logic [15:0] THRESHOLD_RESET = 16'd2;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } pfrs_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } pfrs_div_rsp_t;

endpackage
`default_nettype wire

// ===== design/pfrs_if.sv =====
// Valid/ready channel interfaces for the input and result items.
`default_nettype none
interface pfrs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_pulses;
  logic        link_up;

  modport source (output valid, output total_pulses, output link_up, input ready);
  modport sink (input valid, input total_pulses, input link_up, output ready);
endinterface

interface pfrs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] smoothed_rate;
  logic [15:0] raw_rate;
  logic [31:0] total_volume;

  modport source (output valid, output smoothed_rate, output raw_rate, output total_volume,
                  input ready);
  modport sink (input valid, input smoothed_rate, input raw_rate, input total_volume,
                output ready);
endinterface
`default_nettype wire

// ===== design/pfrs_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module pfrs_div (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  pfrs_pkg::pfrs_div_req_t req_i,
  output pfrs_pkg::pfrs_div_rsp_t rsp_o
);
  import pfrs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W:0]       shifted;
  logic [DVS_W:0]       trial;
  logic                 fits;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      rem_d = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DVD_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

// ===== design/pfrs_hist.sv =====
// Rate history memory with per-entry valid bits; unwritten entries read as zero.
`default_nettype none
module pfrs_hist #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                wr_en_i,
  input  wire   [ADDR_W-1:0] wr_addr_i,
  input  wire   [15:0]       wr_data_i,
  input  wire                rd_en_i,
  input  wire   [ADDR_W-1:0] rd_addr_i,
  output logic  [15:0]       rd_data_o
);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [15:0]      rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : 16'd0;

endmodule
`default_nettype wire

// ===== design/pulse_flow_rate_smoother_unit.sv =====
// Pulse flow rate smoother top level: sequencer around a shared divider and history memory.
// Sequence per item: step, rate division, history write, window sum, mean division, volume division.
// The three passes through the shared 36-step divider (rate, mean, volume) run one after another.
// One item at a time: input ready only while the sequencer idles; output back-pressure holds it in finish.
// Reset: config to 450 / 4 / 2, baseline and primed cleared, pointer zero, history reads zero.
// The history needs no clearing pass; the block is ready in the first cycle after reset.
`default_nettype none
module pulse_flow_rate_smoother_unit #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned GLITCH_CEILING = 1000
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  pfrs_in_if.sink                              in_i,
  pfrs_out_if.source                           out_o,
  input  wire                                  cfg_we_i,
  input  wire   [pfrs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire   [pfrs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pfrs_pkg::*;

  localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W = RATE_W + CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STEP, ST_RATE_GO, ST_RATE_WAIT, ST_WRITE, ST_SUM,
    ST_MEAN_GO, ST_MEAN_WAIT, ST_VOL_GO, ST_VOL_WAIT, ST_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [15:0]         ppl_q, ppl_d;
  logic [3:0]          avg_len_q, avg_len_d;
  logic [15:0]         thr_q, thr_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                link_q, link_d;
  logic [TOTAL_W-1:0]  base_q, base_d;
  logic                primed_q, primed_d;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [RATE_W-1:0]   smooth_q, smooth_d;
  logic [TOTAL_W-1:0]  vol_q, vol_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                out_valid_q, out_valid_d;
  logic [RATE_W-1:0]   out_smooth_q, out_smooth_d;
  logic [RATE_W-1:0]   out_rate_q, out_rate_d;
  logic [TOTAL_W-1:0]  out_vol_q, out_vol_d;

  logic [15:0]         div_val;
  logic [CNT_W-1:0]    win;
  logic                rd_en;
  logic [RATE_W-1:0]   rd_data;
  pfrs_div_req_t       div_req;
  pfrs_div_rsp_t       div_rsp;

  assign div_val = (ppl_q == 16'd0) ? 16'd1 : ppl_q;

  always_comb begin
    if ({28'd0, avg_len_q} > 32'(HISTORY_DEPTH)) begin
      win = CNT_W'(HISTORY_DEPTH);
    end else if (avg_len_q == 4'd0) begin
      win = CNT_W'(1);
    end else begin
      win = CNT_W'(avg_len_q);
    end
  end

  assign rd_en = (state_q == ST_SUM) && (idx_q < n_q);

  pfrs_hist #(
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (state_q == ST_WRITE),
    .wr_addr_i (ptr_q),
    .wr_data_i (rate_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[PTR_W-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    div_req.start = (state_q == ST_RATE_GO) || (state_q == ST_MEAN_GO) ||
                    (state_q == ST_VOL_GO);
    case (state_q)
      ST_MEAN_GO: begin
        div_req.dividend = DVD_W'(sum_q);
        div_req.divisor  = DVS_W'(n_q);
      end
      ST_VOL_GO: begin
        div_req.dividend = DVD_W'(total_q) * DVD_W'(VOL_MUL);
        div_req.divisor  = div_val;
      end
      default: begin
        div_req.dividend = DVD_W'(prod_q);
        div_req.divisor  = div_val;
      end
    endcase
  end

  pfrs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    logic [TOTAL_W-1:0] diff;
    logic [RATE_W-1:0]  delta;
    logic [CNT_W-1:0]   ptr_nxt;
    logic [RATE_W-1:0]  mean;

    state_d      = state_q;
    ppl_d        = ppl_q;
    avg_len_d    = avg_len_q;
    thr_d        = thr_q;
    total_d      = total_q;
    link_d       = link_q;
    base_d       = base_q;
    primed_d     = primed_q;
    ptr_d        = ptr_q;
    n_d          = n_q;
    prod_d       = prod_q;
    rate_d       = rate_q;
    smooth_d     = smooth_q;
    vol_d        = vol_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q;
    out_smooth_d = out_smooth_q;
    out_rate_d   = out_rate_q;
    out_vol_d    = out_vol_q;
    diff         = total_q - base_q;
    delta        = '0;
    ptr_nxt      = CNT_W'(ptr_q) + CNT_W'(1);
    mean         = div_rsp.quotient[RATE_W-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PULSES_PER_LITRE:  ppl_d = cfg_data_i;
        CFG_AVERAGE_LENGTH:    avg_len_d = cfg_data_i[3:0];
        CFG_NO_FLOW_THRESHOLD: thr_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          total_d = in_i.total_pulses;
          link_d  = in_i.link_up;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!link_q) begin
          primed_d = 1'b0;
        end else if (!primed_q) begin
          base_d   = total_q;
          primed_d = 1'b1;
        end else if (total_q < base_q) begin
          base_d = total_q;
        end else begin
          base_d = total_q;
          if (diff <= 32'(GLITCH_CEILING)) begin
            delta = diff[RATE_W-1:0];
          end
        end
        prod_d  = PROD_W'(delta) * PROD_W'(RATE_MUL);
        n_d     = win;
        if (CNT_W'(ptr_q) >= win) begin
          ptr_d = '0;
        end
        state_d = ST_RATE_GO;
      end
      ST_RATE_GO: state_d = ST_RATE_WAIT;
      ST_RATE_WAIT: begin
        if (div_rsp.done) begin
          rate_d  = (div_rsp.quotient > DVD_W'(16'hFFFF)) ? 16'hFFFF :
                    div_rsp.quotient[RATE_W-1:0];
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ptr_d   = (ptr_nxt >= n_q) ? '0 : PTR_W'(ptr_nxt);
        sum_d   = '0;
        idx_d   = '0;
        pend_d  = 1'b0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        pend_d = rd_en;
        if (rd_en) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (pend_q) begin
          sum_d = sum_q + SUM_W'(rd_data);
        end
        if (!rd_en && !pend_q) begin
          state_d = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (div_rsp.done) begin
          smooth_d = (mean < thr_q) ? '0 : mean;
          state_d  = ST_VOL_GO;
        end
      end
      ST_VOL_GO: state_d = ST_VOL_WAIT;
      ST_VOL_WAIT: begin
        if (div_rsp.done) begin
          vol_d   = (div_rsp.quotient > DVD_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF :
                    div_rsp.quotient[TOTAL_W-1:0];
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_smooth_d = smooth_q;
          out_rate_d   = rate_q;
          out_vol_d    = vol_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ppl_q        <= PPL_RESET;
      avg_len_q    <= AVG_LEN_RESET;
      thr_q        <= THRESHOLD_RESET;
      total_q      <= '0;
      link_q       <= 1'b0;
      base_q       <= '0;
      primed_q     <= 1'b0;
      ptr_q        <= '0;
      n_q          <= CNT_W'(1);
      prod_q       <= '0;
      rate_q       <= '0;
      smooth_q     <= '0;
      vol_q        <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
      out_smooth_q <= '0;
      out_rate_q   <= '0;
      out_vol_q    <= '0;
    end else begin
      state_q      <= state_d;
      ppl_q        <= ppl_d;
      avg_len_q    <= avg_len_d;
      thr_q        <= thr_d;
      total_q      <= total_d;
      link_q       <= link_d;
      base_q       <= base_d;
      primed_q     <= primed_d;
      ptr_q        <= ptr_d;
      n_q          <= n_d;
      prod_q       <= prod_d;
      rate_q       <= rate_d;
      smooth_q     <= smooth_d;
      vol_q        <= vol_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      sum_q        <= sum_d;
      out_valid_q  <= out_valid_d;
      out_smooth_q <= out_smooth_d;
      out_rate_q   <= out_rate_d;
      out_vol_q    <= out_vol_d;
    end
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.smoothed_rate = out_smooth_q;
  assign out_o.raw_rate      = out_rate_q;
  assign out_o.total_volume  = out_vol_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_RATE_WAIT || state_q == ST_MEAN_WAIT ||
                      state_q == ST_VOL_WAIT))
    else $error("divider result outside a wait state");

  a_sum_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (idx_q <= n_q))
    else $error("history read index beyond window");

  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (CNT_W'(ptr_q) < n_q))
    else $error("history pointer outside window after write");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for pulse_flow_rate_smoother_unit: random traffic and config phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfrs_pkg::*;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned GLITCH_MAX = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] total;
    logic        link_up;
  } tick_t;

  typedef struct packed {
    logic [15:0] smoothed;
    logic [15:0] raw;
    logic [31:0] volume;
  } flow_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        tick_valid = 1'b0;
  logic [31:0] tick_total = '0;
  logic        tick_link = 1'b0;
  logic        flow_ready = 1'b0;

  pfrs_in_if  tick_if ();
  pfrs_out_if flow_if ();

  assign tick_if.valid        = tick_valid;
  assign tick_if.total_pulses = tick_total;
  assign tick_if.link_up      = tick_link;
  assign flow_if.ready        = flow_ready;

  pulse_flow_rate_smoother_unit #(
    .HISTORY_DEPTH (DEPTH),
    .GLITCH_CEILING(GLITCH_MAX)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (tick_if),
    .out_o     (flow_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the block's registers and state
  logic [15:0] model_ppl = PPL_RESET;
  logic [3:0]  model_avg = AVG_LEN_RESET;
  logic [15:0] model_thr = THRESHOLD_RESET;
  logic [31:0] model_base = '0;
  logic        model_primed = 1'b0;
  logic [15:0] model_hist [DEPTH] = '{default: '0};
  int unsigned model_ptr = 0;

  tick_t pending_ticks [$];
  flow_t flow_expected [$];

  int mismatches = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int settings_applied = 0;
  int n_primes = 0;
  int n_drops = 0;
  int n_backward = 0;
  int n_glitch = 0;
  int n_rate_sat = 0;
  int n_vol_sat = 0;
  int n_zeroed = 0;

  logic [31:0] gen_total = '0;

  function automatic flow_t predict_flow(tick_t t);
    logic [63:0] delta;
    logic [63:0] div;
    logic [63:0] rate;
    logic [63:0] vol;
    logic [63:0] sum;
    logic [63:0] mean;
    int unsigned win;
    flow_t r;
    delta = '0;
    if (!t.link_up) begin
      model_primed = 1'b0;
      n_drops++;
    end else if (!model_primed) begin
      model_base = t.total;
      model_primed = 1'b1;
      n_primes++;
    end else if (t.total < model_base) begin
      model_base = t.total;
      n_backward++;
    end else begin
      delta = {32'd0, t.total} - {32'd0, model_base};
      model_base = t.total;
      if (delta > GLITCH_MAX) begin
        delta = '0;
        n_glitch++;
      end
    end
    div = (model_ppl == 16'd0) ? 64'd1 : {48'd0, model_ppl};
    rate = (delta * RATE_MUL) / div;
    if (rate > 64'hFFFF) begin
      rate = 64'hFFFF;
      n_rate_sat++;
    end
    win = {28'd0, model_avg};
    if (win < 1) win = 1;
    if (win > DEPTH) win = DEPTH;
    if (model_ptr >= win) model_ptr = 0;
    model_hist[model_ptr] = rate[15:0];
    model_ptr++;
    if (model_ptr >= win) model_ptr = 0;
    sum = '0;
    for (int i = 0; i < win; i++) sum += model_hist[i];
    mean = sum / win;
    if (mean < model_thr) begin
      if (mean != 0) n_zeroed++;
      mean = '0;
    end
    vol = ({32'd0, t.total} * VOL_MUL) / div;
    if (vol > 64'hFFFF_FFFF) begin
      vol = 64'hFFFF_FFFF;
      n_vol_sat++;
    end
    r.smoothed = mean[15:0];
    r.raw = rate[15:0];
    r.volume = vol[31:0];
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch, %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_tick(logic [31:0] total, logic link_up);
    tick_t t;
    t.total = total;
    t.link_up = link_up;
    pending_ticks.push_back(t);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PULSES_PER_LITRE: model_ppl = data;
      CFG_AVERAGE_LENGTH: model_avg = data[3:0];
      CFG_NO_FLOW_THRESHOLD: model_thr = data;
      default: ;
    endcase
    settings_applied++;
  endtask

  // Wait until every queued item is accepted and every result has come back
  task automatic settle();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || tick_valid || flow_expected.size() != 0);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic queue_random_ticks(int count);
    int unsigned pick;
    logic [31:0] delta;
    logic [31:0] total;
    logic link_up;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      link_up = 1'b1;
      if (pick < 70) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: delta = $urandom_range(0, 60);
          5, 6, 7, 8: delta = $urandom_range(61, GLITCH_MAX);
          default: delta = $urandom_range(GLITCH_MAX, GLITCH_MAX + 1);
        endcase
        total = gen_total + delta;
      end else if (pick < 80) begin
        total = gen_total + $urandom_range(GLITCH_MAX + 1, 200000);
      end else if (pick < 87) begin
        total = (gen_total == 0) ? 32'd0 : $urandom_range(0, gen_total - 1);
      end else if (pick < 94) begin
        total = gen_total + $urandom_range(0, 2000);
        link_up = 1'b0;
      end else begin
        total = $urandom;
        link_up = 1'($urandom_range(0, 1));
      end
      gen_total = total;
      push_tick(total, link_up);
    end
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    tick_t cur;
    if (!rst_ni) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && tick_if.ready) begin
        cur.total = tick_total;
        cur.link_up = tick_link;
        flow_expected.push_back(predict_flow(cur));
        ticks_sent++;
      end
      if (!tick_valid || tick_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          tick_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          cur = pending_ticks.pop_front();
          tick_total <= cur.total;
          tick_link <= cur.link_up;
          tick_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 9) < 6) gap_left = 0;
            else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(20, 300);
            else gap_left = $urandom_range(1, 20);
          end
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stretches of free flow or of a random stall mask
  int stall_span = 0;
  logic [31:0] stall_mask = '0;
  logic stall_free = 1'b1;
  logic [4:0] stall_phase = '0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      flow_ready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_span = $urandom_range(50, 400);
        stall_mask = $urandom;
        stall_free = ($urandom_range(0, 2) == 0);
      end else begin
        stall_span--;
      end
      stall_phase++;
      flow_ready <= stall_free | stall_mask[stall_phase];
    end
  end

  always @(posedge clk_i) begin
    flow_t want;
    if (rst_ni && flow_if.valid && flow_if.ready) begin
      if (flow_expected.size() == 0) begin
        flag_mismatch("result with no tick pending", 32'(flow_if.raw_rate), 32'd0);
      end else begin
        want = flow_expected.pop_front();
        if (flow_if.smoothed_rate !== want.smoothed)
          flag_mismatch("smoothed_rate", 32'(flow_if.smoothed_rate), 32'(want.smoothed));
        if (flow_if.raw_rate !== want.raw)
          flag_mismatch("raw_rate", 32'(flow_if.raw_rate), 32'(want.raw));
        if (flow_if.total_volume !== want.volume)
          flag_mismatch("total_volume", flow_if.total_volume, want.volume);
        results_checked++;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("pulse_flow_rate_smoother_unit regression: fail");
    $finish;
  end

  initial begin
    logic [15:0] ppl;
    logic [15:0] thr;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: link loss, priming, glitch edge, backwards counter
    push_tick(32'd0, 1'b0);
    push_tick(32'd100, 1'b1);
    push_tick(32'd550, 1'b1);
    push_tick(32'd1550, 1'b1);
    push_tick(32'd2551, 1'b1);
    push_tick(32'd2000, 1'b1);
    push_tick(32'd2000, 1'b1);
    push_tick(32'd2001, 1'b1);
    push_tick(32'd5000, 1'b0);
    push_tick(32'd5000, 1'b1);
    push_tick(32'hFFFF_FFFF, 1'b1);
    push_tick(32'd0, 1'b1);
    push_tick(32'd1000, 1'b1);
    settle();

    // Unit calibration, oversized window, no threshold: saturate rate and volume
    write_reg(CFG_PULSES_PER_LITRE, 16'd1);
    write_reg(CFG_AVERAGE_LENGTH, 16'd15);
    write_reg(CFG_NO_FLOW_THRESHOLD, 16'd0);
    push_tick(32'hFFFF_F000, 1'b1);
    push_tick(32'hFFFF_F3E8, 1'b1);
    push_tick(32'hFFFF_F3F2, 1'b1);
    push_tick(32'hFFFF_FFFF, 1'b1);
    push_tick(32'hFFFF_FFFF, 1'b0);
    settle();

    // Zero calibration, zero window, full threshold; pointer restarts
    write_reg(CFG_PULSES_PER_LITRE, 16'd0);
    write_reg(CFG_AVERAGE_LENGTH, 16'd0);
    write_reg(CFG_NO_FLOW_THRESHOLD, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'($urandom));
    push_tick(32'd1000, 1'b1);
    push_tick(32'd2000, 1'b1);
    push_tick(32'd2001, 1'b1);
    push_tick(32'd0, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 7))
        0: ppl = 16'd0;
        1: ppl = 16'd1;
        2: ppl = 16'($urandom_range(2, 20));
        3: ppl = 16'hFFFF;
        4: ppl = 16'($urandom_range(0, 65535));
        default: ppl = 16'($urandom_range(200, 1000));
      endcase
      case ($urandom_range(0, 5))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = 16'($urandom_range(0, 65535));
        default: thr = 16'($urandom_range(0, 400));
      endcase
      write_reg(CFG_PULSES_PER_LITRE, ppl);
      write_reg(CFG_AVERAGE_LENGTH, 16'($urandom_range(0, 15)));
      write_reg(CFG_NO_FLOW_THRESHOLD, thr);
      if (p == 3) write_reg(CFG_UNUSED, 16'($urandom));
      gen_total = (p % 2 == 0) ? 32'($urandom) : 32'($urandom_range(0, 5000));
      queue_random_ticks(94);
      settle();
    end

    repeat (200) @(negedge clk_i);
    $display("%0d ticks, %0d results checked, %0d register writes, %0d mismatches",
             ticks_sent, results_checked, settings_applied, mismatches);
    $display("primes %0d, link drops %0d, backwards %0d, glitches %0d, ",
             n_primes, n_drops, n_backward, n_glitch,
             "rate sat %0d, volume sat %0d, thresholded %0d",
             n_rate_sat, n_vol_sat, n_zeroed);
    if (mismatches == 0)
      $display("pulse_flow_rate_smoother_unit regression: pass");
    else
      $display("pulse_flow_rate_smoother_unit regression: fail");
    $finish;
  end

endmodule

// ===== pulse_flow_rate_smoother_unit.f =====
design/pfrs_pkg.sv
design/pfrs_if.sv
design/pfrs_div.sv
design/pfrs_hist.sv
design/pulse_flow_rate_smoother_unit.sv
tb/tb.sv
